/* src/fcn_pkg.sv */
// Package for the frame complexity normalizer: register codes, reset values,
// pipeline schedule, fixed-point constants and the per-stage item type.
// Used by frame_complexity_normalizer and tb_top; depends on nothing else.
package fcn_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int IN_DATA_W   = 152;
  localparam int OUT_DATA_W  = 120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_WEIGHT_SPATIAL  = 3'd2,
    CFG_WEIGHT_MOTION   = 3'd3,
    CFG_WEIGHT_RESIDUAL = 3'd4,
    CFG_WEIGHT_ERROR    = 3'd5
  } cfg_idx_t;

  localparam logic [13:0] RST_FRAME_WIDTH  = 14'd1920;
  localparam logic [13:0] RST_FRAME_HEIGHT = 14'd1080;
  localparam logic [16:0] RST_WEIGHT       = 17'd16384;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  // 65025 * 256: at or above this the root of x / 65025 reaches one
  localparam logic [23:0] ROOT_SAT_LIM  = 24'd16646400;
  // 2^24 / 255 rounded down; (s + 1) * RECIP_255 >> 24 is s / 255 below 2^24
  localparam logic [16:0] RECIP_255     = 17'd65793;

  // stage schedule
  localparam int DIV_FIRST  = 3;
  localparam int DIV_STEPS  = 32;
  localparam int NR_STEPS   = 16;
  localparam int RT_STEPS   = 24;
  localparam int ST_RECIP   = DIV_FIRST + RT_STEPS;
  localparam int SQ_FIRST   = DIV_FIRST + DIV_STEPS;
  localparam int SQ_STEPS   = 16;
  localparam int ST_NORM    = SQ_FIRST + SQ_STEPS;
  localparam int ST_MUL     = ST_NORM + 1;
  localparam int ST_SUM     = ST_MUL + 1;
  localparam int NUM_STAGES = ST_SUM + 2;

  // motion lane: restoring divider state, then root state
  typedef struct packed {
    logic [28:0] rem;
    logic [31:0] qn;
    logic [16:0] srem;
    logic [15:0] root;
    logic        sat;
  } root_unit_t;

  // variance / MSE lane: root of x * 2^24, then divide by 255
  typedef struct packed {
    logic [47:0] rad;
    logic [24:0] srem;
    logic [23:0] root;
    logic [15:0] q;
    logic        sat;
  } rt_lane_t;

  typedef struct packed {
    logic [23:0]      sp_var;
    logic [23:0]      mse_q;
    logic [17:0]      mv;
    logic             mnz;
    logic [39:0]      ac;
    logic [39:0]      bits;
    logic [35:0]      mm;
    logic [40:0]      m2;
    logic             dz;
    rt_lane_t [1:0]   rl;
    root_unit_t       mo;
    logic             pz;
    logic             nr_sat;
    logic [35:0]      nr_rem;
    logic [15:0]      nr_q;
    logic             bp_sat;
    logic [27:0]      bp_rem;
    logic [31:0]      bp_q;
    logic [16:0]      n_sp;
    logic [16:0]      n_mo;
    logic [16:0]      n_re;
    logic [16:0]      n_er;
    logic [31:0]      bpp;
    logic [33:0]      p_sp;
    logic [33:0]      p_mo;
    logic [33:0]      p_re;
    logic [33:0]      p_er;
    logic [16:0]      score;
  } pipe_t;

endpackage

/* src/frame_complexity_normalizer.sv */
// Frame complexity normalizer top level: config registers and the
// divide / square-root pipeline. Depends on fcn_pkg.
//
// Usage: one item on s_axis carries a frame's raw statistics; one item on
// m_axis returns the normalized metrics, bits per pixel and the weighted
// score. Items are independent; one can enter every cycle without a stall.
// Variance and MSE take a 24-step digit-by-digit root of x * 2^24, then
// a reciprocal multiply by 1/255; motion and bits per pixel take 32
// restoring divide steps, motion then 16 root steps; each step is one
// pipeline stage. A normalize stage, a stage of four 17x17 multipliers
// and a sum / clamp stage follow.
// Throughput is one item per cycle while m_axis_tready stays high.
// When the receiver stalls the whole pipe holds and s_axis_tready drops;
// nothing is lost or repeated. A frame size change passes through the size
// registers, then the registered pixel count and diagonal, then pix255.
// Reset (rst, synchronous) empties the pipe and loads 1920x1080 with all four
// weights at one quarter; configuration writes go through cfg_we / cfg_addr /
// cfg_wdata; the user must make them while no item is in flight (unchecked).
module frame_complexity_normalizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fcn_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fcn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // spatial_var, motion_mag, ac_energy_sum, mean_sq_error, bit_estimate
  input  logic [fcn_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sp_level, mo_level, re_level, er_level, pixel_bit_rate, unified_score
  output logic [fcn_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import fcn_pkg::*;

  logic [13:0] frame_width;
  logic [13:0] frame_height;
  logic [16:0] weight_spatial;
  logic [16:0] weight_motion;
  logic [16:0] weight_residual;
  logic [16:0] weight_error;

  logic [27:0] pix;
  logic [28:0] diag;
  logic [35:0] pix255;

  pipe_t                 st [NUM_STAGES];
  pipe_t                 nx [NUM_STAGES-1];
  pipe_t                 cap;
  logic [NUM_STAGES-1:0] vld;
  logic                  en;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= RST_FRAME_WIDTH;
      frame_height    <= RST_FRAME_HEIGHT;
      weight_spatial  <= RST_WEIGHT;
      weight_motion   <= RST_WEIGHT;
      weight_residual <= RST_WEIGHT;
      weight_error    <= RST_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_wdata[13:0];
        CFG_FRAME_HEIGHT:    frame_height    <= cfg_wdata[13:0];
        CFG_WEIGHT_SPATIAL:  weight_spatial  <= cfg_wdata;
        CFG_WEIGHT_MOTION:   weight_motion   <= cfg_wdata;
        CFG_WEIGHT_RESIDUAL: weight_residual <= cfg_wdata;
        CFG_WEIGHT_ERROR:    weight_error    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame geometry derived from the size registers
  always_ff @(posedge clk) begin
    pix    <= {14'b0, frame_width} * {14'b0, frame_height};
    diag   <= {15'b0, frame_width} * {15'b0, frame_width} +
              {15'b0, frame_height} * {15'b0, frame_height};
    pix255 <= {pix, 8'b0} - {8'b0, pix};
  end

  assign en            = !vld[NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    cap        = '0;
    cap.sp_var = s_axis_tdata[23:0];
    cap.mv     = s_axis_tdata[41:24];
    cap.ac     = s_axis_tdata[81:42];
    cap.mse_q  = s_axis_tdata[105:82];
    cap.bits   = s_axis_tdata[145:106];
  end

  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_stage
    always_comb begin
      pipe_t       p;
      logic [29:0] dt;
      logic [18:0] sq_t;
      logic [18:0] sq_tr;
      logic [26:0] rt_t;
      logic [26:0] rt_tr;
      logic [24:0] rs;
      logic [41:0] rp;
      logic [36:0] nt;
      logic [28:0] bt;
      logic [35:0] sum;
      logic [19:0] hi;
      p     = st[k];
      dt    = '0;
      sq_t  = '0;
      sq_tr = '0;
      rt_t  = '0;
      rt_tr = '0;
      rs    = '0;
      rp    = '0;
      nt    = '0;
      bt    = '0;
      sum   = '0;
      hi    = '0;
      if (k == 0) begin
        p.rl[0].sat  = p.sp_var >= ROOT_SAT_LIM;
        p.rl[0].rad  = {p.sp_var, 24'b0};
        p.rl[0].srem = '0;
        p.rl[0].root = '0;
        p.rl[0].q    = '0;
        p.rl[1].sat  = p.mse_q >= ROOT_SAT_LIM;
        p.rl[1].rad  = {p.mse_q, 24'b0};
        p.rl[1].srem = '0;
        p.rl[1].root = '0;
        p.rl[1].q    = '0;
        p.pz         = pix == '0;
        p.bp_sat     = {4'b0, p.bits} >= {pix, 16'b0};
        p.bp_rem     = {4'b0, p.bits[39:16]};
        p.bp_q       = {p.bits[15:0], 16'b0};
        p.mm         = {18'b0, p.mv} * {18'b0, p.mv};
        p.mnz        = |p.mv;
      end
      if (k == 1) begin
        // times 25 as 16 + 8 + 1
        p.m2     = {1'b0, p.mm, 4'b0} + {2'b0, p.mm, 3'b0} + {5'b0, p.mm};
        p.nr_sat = p.ac >= {4'b0, pix255};
        p.nr_rem = p.ac[35:0];
        p.nr_q   = '0;
      end
      if (k == 2) begin
        p.dz      = diag == '0;
        p.mo.sat  = p.m2 >= {6'b0, diag, 6'b0};
        p.mo.rem  = p.m2[34:6];
        p.mo.qn   = {p.m2[5:0], 26'b0};
        p.mo.srem = '0;
        p.mo.root = '0;
      end
      if (k >= DIV_FIRST && k < DIV_FIRST + RT_STEPS) begin
        // bring down two radicand bits, try root*4+1
        for (int u = 0; u < 2; u++) begin
          rt_t  = {p.rl[u].srem, p.rl[u].rad[47:46]};
          rt_tr = {1'b0, p.rl[u].root, 2'b01};
          if (rt_t >= rt_tr) begin
            rt_t         = rt_t - rt_tr;
            p.rl[u].root = {p.rl[u].root[22:0], 1'b1};
          end else begin
            p.rl[u].root = {p.rl[u].root[22:0], 1'b0};
          end
          p.rl[u].srem = rt_t[24:0];
          p.rl[u].rad  = {p.rl[u].rad[45:0], 2'b00};
        end
      end
      if (k == ST_RECIP) begin
        // divide the root by 255 through the reciprocal
        for (int u = 0; u < 2; u++) begin
          rs        = {1'b0, p.rl[u].root} + 25'd1;
          rp        = {17'b0, rs} * {25'b0, RECIP_255};
          p.rl[u].q = rp[39:24];
        end
      end
      if (k >= DIV_FIRST && k < DIV_FIRST + DIV_STEPS) begin
        dt = {p.mo.rem, p.mo.qn[31]};
        if (dt >= {1'b0, diag}) begin
          dt      = dt - {1'b0, diag};
          p.mo.qn = {p.mo.qn[30:0], 1'b1};
        end else begin
          p.mo.qn = {p.mo.qn[30:0], 1'b0};
        end
        p.mo.rem = dt[28:0];
        bt = {p.bp_rem, p.bp_q[31]};
        if (bt >= {1'b0, pix}) begin
          bt     = bt - {1'b0, pix};
          p.bp_q = {p.bp_q[30:0], 1'b1};
        end else begin
          p.bp_q = {p.bp_q[30:0], 1'b0};
        end
        p.bp_rem = bt[27:0];
      end
      if (k >= DIV_FIRST && k < DIV_FIRST + NR_STEPS) begin
        nt = {p.nr_rem, 1'b0};
        if (nt >= {1'b0, pix255}) begin
          nt     = nt - {1'b0, pix255};
          p.nr_q = {p.nr_q[14:0], 1'b1};
        end else begin
          p.nr_q = {p.nr_q[14:0], 1'b0};
        end
        p.nr_rem = nt[35:0];
      end
      if (k >= SQ_FIRST && k < SQ_FIRST + SQ_STEPS) begin
        // bring down two quotient bits, try root*4+1
        sq_t  = {p.mo.srem, p.mo.qn[31:30]};
        sq_tr = {1'b0, p.mo.root, 2'b01};
        if (sq_t >= sq_tr) begin
          sq_t      = sq_t - sq_tr;
          p.mo.root = {p.mo.root[14:0], 1'b1};
        end else begin
          p.mo.root = {p.mo.root[14:0], 1'b0};
        end
        p.mo.srem = sq_t[16:0];
        p.mo.qn   = {p.mo.qn[29:0], 2'b00};
      end
      if (k == ST_NORM) begin
        p.n_sp = p.rl[0].sat ? ONE_Q16 : {1'b0, p.rl[0].q};
        p.n_er = p.rl[1].sat ? ONE_Q16 : {1'b0, p.rl[1].q};
        if (p.dz) begin
          p.n_mo = p.mnz ? ONE_Q16 : '0;
        end else begin
          p.n_mo = p.mo.sat ? ONE_Q16 : {1'b0, p.mo.root};
        end
        if (p.pz) begin
          p.n_re = '0;
          p.bpp  = '0;
        end else begin
          p.n_re = p.nr_sat ? ONE_Q16 : {1'b0, p.nr_q};
          p.bpp  = p.bp_sat ? '1 : p.bp_q;
        end
      end
      if (k == ST_MUL) begin
        p.p_sp = {17'b0, weight_spatial}  * {17'b0, p.n_sp};
        p.p_mo = {17'b0, weight_motion}   * {17'b0, p.n_mo};
        p.p_re = {17'b0, weight_residual} * {17'b0, p.n_re};
        p.p_er = {17'b0, weight_error}    * {17'b0, p.n_er};
      end
      if (k == ST_SUM) begin
        sum     = {2'b0, p.p_sp} + {2'b0, p.p_mo} + {2'b0, p.p_re} + {2'b0, p.p_er};
        hi      = sum[35:16];
        p.score = (hi > {3'b0, ONE_Q16}) ? ONE_Q16 : hi[16:0];
      end
      nx[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // advance payload with the valid bits; hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= cap;
      for (int k = 0; k < NUM_STAGES - 1; k++) begin
        st[k+1] <= nx[k];
      end
    end
  end

  assign m_axis_tvalid = vld[NUM_STAGES-1];
  assign m_axis_tdata  = {3'b0,
                          st[NUM_STAGES-1].score,
                          st[NUM_STAGES-1].bpp,
                          st[NUM_STAGES-1].n_er,
                          st[NUM_STAGES-1].n_re,
                          st[NUM_STAGES-1].n_mo,
                          st[NUM_STAGES-1].n_sp};

endmodule

/* tb/sv/tb_top.sv */
// Testbench for frame_complexity_normalizer: streams frame statistics through
// the block under several register settings and checks every result against a
// built-in predictor. Depends on fcn_pkg and the block's RTL.

class norm_scoreboard;
  logic [119:0] expected_q[$];
  int unsigned  n_fail;
  int unsigned  n_checked;
  logic [13:0]  fw, fh;
  logic [16:0]  w_sp, w_mo, w_re, w_er;

  function logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function logic [16:0] clamp1(logic [63:0] v);
    return (v > 64'd65536) ? 17'd65536 : v[16:0];
  endfunction

  function logic [16:0] root_norm(logic [23:0] x);
    logic [63:0] q;
    q = ({40'd0, x} << 24) / 64'd65025;
    return clamp1(isqrt(q));
  endfunction

  function logic [119:0] predict_metrics(logic [151:0] d);
    logic [63:0]  pix, diag, m2, sum, mv;
    logic [127:0] t;
    logic [16:0]  ns, nm, nr, ne;
    logic [31:0]  bp;
    pix  = {50'd0, fw} * {50'd0, fh};
    diag = {50'd0, fw} * {50'd0, fw} + {50'd0, fh} * {50'd0, fh};
    mv   = {46'd0, d[41:24]};
    ns   = root_norm(d[23:0]);
    ne   = root_norm(d[105:82]);
    if (diag == 0) nm = (mv != 0) ? 17'd65536 : 17'd0;
    else begin
      m2 = 64'd25 * mv * mv;
      if (m2 >= 64'd64 * diag) nm = 17'd65536;
      else nm = clamp1(isqrt((m2 << 26) / diag));
    end
    if (pix == 0) begin
      nr = '0;
      bp = '0;
    end else begin
      t  = ({88'd0, d[81:42]} << 16) / (128'd255 * {64'd0, pix});
      nr = (t > 128'd65536) ? 17'd65536 : t[16:0];
      t  = ({88'd0, d[145:106]} << 16) / {64'd0, pix};
      bp = (t > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    end
    sum = {47'd0, w_sp} * {47'd0, ns} + {47'd0, w_mo} * {47'd0, nm} +
          {47'd0, w_re} * {47'd0, nr} + {47'd0, w_er} * {47'd0, ne};
    return {3'd0, clamp1(sum >> 16), bp, ne, nr, nm, ns};
  endfunction

  function void note_frame(logic [151:0] d);
    expected_q.push_back(predict_metrics(d));
  endfunction

  function void check_result(logic [119:0] got);
    logic [119:0] e;
    if (expected_q.size() == 0) begin
      $error("result with no expectation: %h", got);
      n_fail++;
      return;
    end
    e = expected_q.pop_front();
    n_checked++;
    if (got[16:0] !== e[16:0]) begin
      $error("sp_level exp %0d got %0d", e[16:0], got[16:0]); n_fail++;
    end
    if (got[33:17] !== e[33:17]) begin
      $error("mo_level exp %0d got %0d", e[33:17], got[33:17]); n_fail++;
    end
    if (got[50:34] !== e[50:34]) begin
      $error("re_level exp %0d got %0d", e[50:34], got[50:34]); n_fail++;
    end
    if (got[67:51] !== e[67:51]) begin
      $error("er_level exp %0d got %0d", e[67:51], got[67:51]); n_fail++;
    end
    if (got[99:68] !== e[99:68]) begin
      $error("pixel_bit_rate exp %0d got %0d", e[99:68], got[99:68]); n_fail++;
    end
    if (got[116:100] !== e[116:100]) begin
      $error("unified_score exp %0d got %0d", e[116:100], got[116:100]); n_fail++;
    end
  endfunction
endclass

module tb_top;
  import fcn_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  norm_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned n_sent;
  bit hold_sink;
  bit stall_seen;

  localparam int LATENCY = 54;
  localparam int WATCHDOG = 20000;

  frame_complexity_normalizer uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_frame(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (s_axis_tvalid && !s_axis_tready && !rst) stall_seen = 1;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int unsigned g;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b1;
        @(negedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:     sb.fw = val[13:0];
      CFG_FRAME_HEIGHT:    sb.fh = val[13:0];
      CFG_WEIGHT_SPATIAL:  sb.w_sp = val;
      CFG_WEIGHT_MOTION:   sb.w_mo = val;
      CFG_WEIGHT_RESIDUAL: sb.w_re = val;
      CFG_WEIGHT_ERROR:    sb.w_er = val;
      default: ;
    endcase
  endtask

  task automatic set_frame(int w, int h, int ws, int wm, int wr, int we);
    write_reg(CFG_FRAME_WIDTH, 17'(w));
    write_reg(CFG_FRAME_HEIGHT, 17'(h));
    write_reg(CFG_WEIGHT_SPATIAL, 17'(ws));
    write_reg(CFG_WEIGHT_MOTION, 17'(wm));
    write_reg(CFG_WEIGHT_RESIDUAL, 17'(wr));
    write_reg(CFG_WEIGHT_ERROR, 17'(we));
    repeat (4) @(negedge clk);
  endtask

  task automatic send_frame(logic [23:0] v, logic [17:0] m, logic [39:0] ac,
                            logic [23:0] mse, logic [39:0] b, bit no_gap);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, b, mse, ac, m, v};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function logic [39:0] rand40();
    logic [39:0] r;
    r = 40'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: r = r >> $urandom_range(0, 39);
      1: r = r >> $urandom_range(16, 32);
      default: ;
    endcase
    return r;
  endfunction

  task automatic random_frames(int n);
    logic [23:0] v, e;
    logic [17:0] m;
    for (int i = 0; i < n; i++) begin
      v = 24'($urandom());
      e = 24'($urandom());
      m = 18'($urandom());
      if ($urandom_range(0, 1)) v = v >> $urandom_range(0, 23);
      if ($urandom_range(0, 1)) e = e >> $urandom_range(0, 23);
      if ($urandom_range(0, 1)) m = m >> $urandom_range(0, 17);
      send_frame(v, m, rand40(), e, rand40(), 1'b0);
    end
  endtask

  initial begin
    sb = new();
    sb.fw = RST_FRAME_WIDTH;
    sb.fh = RST_FRAME_HEIGHT;
    sb.w_sp = RST_WEIGHT; sb.w_mo = RST_WEIGHT;
    sb.w_re = RST_WEIGHT; sb.w_er = RST_WEIGHT;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes and saturation points at reset sizes
    send_frame(24'd0, 18'd0, 40'd0, 24'd0, 40'd0, 1'b1);
    send_frame(24'hFFFFFF, 18'h3FFFF, 40'hFF_FFFF_FFFF, 24'hFFFFFF, 40'hFF_FFFF_FFFF, 1'b1);
    send_frame(24'd16646400, 18'd1, 40'd1, 24'd16646399, 40'd1, 1'b1);
    send_frame(24'd256, 18'd16, 40'd528768000, 24'd1, 40'd2073600, 1'b0);
    send_frame(24'h555555, 18'h2AAAA, 40'hAA_AAAA_AAAA, 24'hAAAAAA, 40'h55_5555_5555, 1'b0);
    drain();

    // zero sizes: zero pixel count and zero diagonal
    set_frame(0, 0, 65536, 65536, 65536, 65536);
    send_frame(24'd1000, 18'd1, 40'd99999, 24'd5000, 40'd12345, 1'b1);
    send_frame(24'd1000, 18'd0, 40'd99999, 24'd5000, 40'd12345, 1'b1);
    drain();
    set_frame(0, 8192, 0, 0, 0, 0);
    send_frame(24'd70000, 18'd300, 40'd4000, 24'd70000, 40'd7, 1'b1);
    drain();
    // smallest frame: bpp and residual saturate; sum exceeds one
    set_frame(1, 1, 65536, 65536, 65536, 65536);
    send_frame(24'd7000000, 18'd3, 40'd300, 24'd9000000, 40'hFF_FFFF_FFFF, 1'b1);
    send_frame(24'd0, 18'd0, 40'd0, 24'd0, 40'd65535, 1'b1);
    random_frames(150);
    drain();

    // largest frame, with a long receiver hold-off to fill the pipe
    set_frame(8192, 8192, 1, 65535, 32768, 0);
    hold_sink = 1;
    for (int i = 0; i < 120; i++)
      send_frame(24'($urandom()), 18'($urandom()), rand40(), 24'($urandom()),
                 rand40(), 1'b1);
    random_frames(200);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_frame($urandom_range(1, 8192), $urandom_range(1, 8192),
                $urandom_range(0, 65536), $urandom_range(0, 65536),
                $urandom_range(0, 65536), $urandom_range(0, 65536));
      random_frames(160);
      drain();
    end
    // small random sizes, where saturation is common
    set_frame($urandom_range(1, 64), $urandom_range(1, 64), 16384, 16384, 16384, 16384);
    random_frames(100);
    drain();

    $display("sent %0d frames over 14 register settings, checked %0d results",
             n_sent, sb.n_checked);
    $display("input stall under receiver hold-off seen: %0d", stall_seen);
    if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* filelist.f */
src/fcn_pkg.sv
src/frame_complexity_normalizer.sv
tb/sv/tb_top.sv
